>>> src/jds_pkg.sv
// Shared types and constants for the joystick deadzone smoother.
`timescale 1ns / 1ps
`default_nettype none
package jds_pkg;

  localparam int AXES = 3;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [31:0] ZERO_TOL = 32'sd269;
  localparam logic signed [32:0] RND_POS = 33'sd32768;
  localparam logic signed [32:0] RND_NEG = 33'sd32767;

  localparam logic [14:0] DEADZONE_RST = 15'd3277;
  localparam logic [14:0] LIN_LIMIT_RST = 15'd4096;
  localparam logic [14:0] ANG_LIMIT_RST = 15'd8192;
  localparam logic [15:0] LIN_SCALE_RST = 16'd4551;
  localparam logic [15:0] ANG_SCALE_RST = 16'd9102;
  localparam logic [16:0] WEIGHT_RST = 17'd13107;

  typedef enum logic [2:0] {
    REG_DEADZONE  = 3'd0,
    REG_LIN_LIMIT = 3'd1,
    REG_ANG_LIMIT = 3'd2,
    REG_LIN_SCALE = 3'd3,
    REG_ANG_SCALE = 3'd4,
    REG_WEIGHT    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [14:0] lin_limit;
    logic [14:0] ang_limit;
    logic [15:0] lin_scale;
    logic [15:0] ang_scale;
    logic [16:0] weight;
    logic [16:0] weight_comp;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mix;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

>>> src/jds_cfg_regs.sv
// Configuration register file for the joystick deadzone smoother.
`timescale 1ns / 1ps
`default_nettype none
module jds_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [16:0]  cfg_data,
  output jds_pkg::cfg_t     cfg
);

  jds_pkg::cfg_t cfg_r;
  jds_pkg::cfg_t cfg_nxt;
  logic [16:0]   weight_clamped;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    weight_clamped = (cfg_data > jds_pkg::WEIGHT_ONE) ? jds_pkg::WEIGHT_ONE : cfg_data;
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (jds_pkg::cfg_idx_t'(cfg_index))
        jds_pkg::REG_DEADZONE:  cfg_nxt.deadzone  = cfg_data[14:0];
        jds_pkg::REG_LIN_LIMIT: cfg_nxt.lin_limit = cfg_data[14:0];
        jds_pkg::REG_ANG_LIMIT: cfg_nxt.ang_limit = cfg_data[14:0];
        jds_pkg::REG_LIN_SCALE: cfg_nxt.lin_scale = cfg_data[15:0];
        jds_pkg::REG_ANG_SCALE: cfg_nxt.ang_scale = cfg_data[15:0];
        jds_pkg::REG_WEIGHT: begin
          cfg_nxt.weight      = weight_clamped;
          cfg_nxt.weight_comp = 17'(jds_pkg::WEIGHT_ONE - weight_clamped);
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone    <= jds_pkg::DEADZONE_RST;
      cfg_r.lin_limit   <= jds_pkg::LIN_LIMIT_RST;
      cfg_r.ang_limit   <= jds_pkg::ANG_LIMIT_RST;
      cfg_r.lin_scale   <= jds_pkg::LIN_SCALE_RST;
      cfg_r.ang_scale   <= jds_pkg::ANG_SCALE_RST;
      cfg_r.weight      <= jds_pkg::WEIGHT_RST;
      cfg_r.weight_comp <= 17'(jds_pkg::WEIGHT_ONE - jds_pkg::WEIGHT_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/jds_datapath.sv
// Datapath: deadzone shaping, moving average blend and result register.
`timescale 1ns / 1ps
`default_nettype none
module jds_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  jds_pkg::cfg_t      cfg,
  input  jds_pkg::cmd_t      cmd,
  output jds_pkg::status_t   status,
  input  wire logic [55:0]   in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [47:0]        out_tdata,
  output logic [0:0]         out_tuser
);

  logic signed [15:0] axis      [jds_pkg::AXES];
  logic               present   [jds_pkg::AXES];
  logic [15:0]        scale     [jds_pkg::AXES];
  logic [14:0]        limit     [jds_pkg::AXES];
  logic [16:0]        mag       [jds_pkg::AXES];
  logic [16:0]        excess    [jds_pkg::AXES];
  logic [16:0]        shifted   [jds_pkg::AXES];
  logic [14:0]        sat       [jds_pkg::AXES];
  logic signed [15:0] target    [jds_pkg::AXES];
  logic signed [50:0] sum       [jds_pkg::AXES];
  logic signed [50:0] quot      [jds_pkg::AXES];
  logic signed [32:0] rnd       [jds_pkg::AXES];
  logic               near      [jds_pkg::AXES];
  logic [15:0]        q12       [jds_pkg::AXES];

  logic [31:0]        prod_r    [jds_pkg::AXES];
  logic [31:0]        prod_nxt  [jds_pkg::AXES];
  logic               neg_r     [jds_pkg::AXES];
  logic               neg_nxt   [jds_pkg::AXES];
  logic               zero_r    [jds_pkg::AXES];
  logic               zero_nxt  [jds_pkg::AXES];
  logic signed [33:0] p1_r      [jds_pkg::AXES];
  logic signed [33:0] p1_nxt    [jds_pkg::AXES];
  logic signed [49:0] p2_r      [jds_pkg::AXES];
  logic signed [49:0] p2_nxt    [jds_pkg::AXES];
  logic signed [31:0] avg_r     [jds_pkg::AXES];
  logic signed [31:0] avg_nxt   [jds_pkg::AXES];

  logic               stop_sent_r;
  logic               stop_sent_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [47:0]        out_data_r;
  logic [47:0]        out_data_nxt;
  logic               out_stop_r;
  logic               out_stop_nxt;
  logic               all_near;
  logic               send;

  assign axis[0] = $signed(in_tdata[15:0]);
  assign axis[1] = $signed(in_tdata[31:16]);
  assign axis[2] = $signed(in_tdata[47:32]);

  assign present[0] = in_tdata[51:48] >= 4'd2;
  assign present[1] = in_tdata[51:48] >= 4'd1;
  assign present[2] = in_tdata[51:48] >= 4'd4;

  assign scale[0] = cfg.lin_scale;
  assign scale[1] = cfg.lin_scale;
  assign scale[2] = cfg.ang_scale;
  assign limit[0] = cfg.lin_limit;
  assign limit[1] = cfg.lin_limit;
  assign limit[2] = cfg.ang_limit;

  always_comb begin
    for (int i = 0; i < jds_pkg::AXES; i++) begin
      // shape: magnitude, excess over deadzone, scale
      mag[i]      = axis[i][15] ? (17'd0 - {axis[i][15], axis[i]}) : {1'b0, axis[i]};
      excess[i]   = mag[i] - {2'b00, cfg.deadzone};
      prod_nxt[i] = excess[i][15:0] * scale[i];
      neg_nxt[i]  = axis[i][15];
      zero_nxt[i] = (mag[i] < {2'b00, cfg.deadzone}) || !present[i];

      // mix: saturate, restore sign, weight both terms
      shifted[i] = prod_r[i][31:15];
      sat[i]     = (shifted[i] > {2'b00, limit[i]}) ? limit[i] : shifted[i][14:0];
      if (zero_r[i]) begin
        target[i] = 16'sd0;
      end else if (neg_r[i]) begin
        target[i] = $signed(16'd0 - {1'b0, sat[i]});
      end else begin
        target[i] = $signed({1'b0, sat[i]});
      end
      p1_nxt[i] = $signed({1'b0, cfg.weight}) * target[i];
      p2_nxt[i] = $signed({1'b0, cfg.weight_comp}) * avg_r[i];

      // sum: add and divide by 2^16 truncating toward zero
      sum[i]  = $signed({p1_r[i][33], p1_r[i], 16'd0}) +
                $signed({p2_r[i][49], p2_r[i]});
      quot[i] = (sum[i] >>> 16) +
                51'(sum[i][50] && (sum[i][15:0] != 16'd0));
      avg_nxt[i] = quot[i][31:0];

      // emit: near-zero test and rounding to Q4.12
      near[i] = (avg_r[i] > -jds_pkg::ZERO_TOL) && (avg_r[i] < jds_pkg::ZERO_TOL);
      rnd[i]  = ($signed({avg_r[i][31], avg_r[i]}) +
                 (avg_r[i][31] ? jds_pkg::RND_NEG : jds_pkg::RND_POS)) >>> 16;
      q12[i]  = rnd[i][15:0];
    end
  end

  always_comb begin
    all_near      = near[0] && near[1] && near[2];
    send          = !(all_near && stop_sent_r);
    stop_sent_nxt = cmd.emit ? all_near : stop_sent_r;
    out_valid_nxt = (out_valid_r && !out_tready) || (cmd.emit && send);
    out_data_nxt  = out_data_r;
    out_stop_nxt  = out_stop_r;
    if (cmd.emit && send) begin
      if (all_near) begin
        out_data_nxt = 48'd0;
        out_stop_nxt = 1'b1;
      end else begin
        out_data_nxt = {q12[2], q12[1], q12[0]};
        out_stop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r <= prod_nxt;
      neg_r  <= neg_nxt;
      zero_r <= zero_nxt;
    end
    if (cmd.mix) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    out_data_r <= out_data_nxt;
    out_stop_r <= out_stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < jds_pkg::AXES; i++) begin
        avg_r[i] <= 32'sd0;
      end
      stop_sent_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sum) begin
        avg_r <= avg_nxt;
      end
      stop_sent_r <= stop_sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign out_tuser       = out_stop_r;

endmodule
`default_nettype wire

>>> src/jds_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module jds_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  jds_pkg::status_t  status,
  output jds_pkg::cmd_t     cmd
);

  jds_pkg::state_t state_r;
  jds_pkg::state_t state_nxt;

  assign in_tready = (state_r == jds_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      jds_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = jds_pkg::ST_MIX;
        end
      end
      jds_pkg::ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = jds_pkg::ST_SUM;
      end
      jds_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = jds_pkg::ST_EMIT;
      end
      jds_pkg::ST_EMIT: begin
        // hold until the result register frees up
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = jds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/joystick_deadzone_smoother_unit.sv
// Top level of the joystick deadzone smoother.
// Usage:
//   in_*  : one item per control tick; in_tdata carries axis_forward [15:0],
//           axis_side [31:16], axis_turn [47:32], axis_count [51:48].
//   out_* : at most one item per input; out_tdata carries vel_forward [15:0],
//           vel_side [31:16], vel_turn [47:32]; out_tuser[0] is is_stop.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Timing: the deadzone shaping multiply runs in the accepting cycle; the MIX,
// SUM and EMIT states then run the weighting multiplies, the averaging add and
// the result decision, and out_tvalid rises once EMIT registers the result. No
// new item is taken before the controller is back in IDLE; the pace is set by the
// four-state controller driving one set of per-axis multipliers and accumulators.
// Reset: registers return to their defaults, averages clear, and no stop item
// is sent until motion has been seen.
// Stall: a result waits in the output register; the next input item is still
// taken, and the block holds in its final step only if a second result is
// ready before the first one leaves.
`timescale 1ns / 1ps
`default_nettype none
module joystick_deadzone_smoother_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // axis_forward, axis_side, axis_turn, axis_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // vel_forward, vel_side, vel_turn
  output logic [0:0]       out_tuser,  // is_stop
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  jds_pkg::cfg_t    cfg;
  jds_pkg::cmd_t    cmd;
  jds_pkg::status_t status;

  jds_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  jds_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> test/tb_joystick_deadzone_smoother_unit.sv
// Testbench for joystick_deadzone_smoother_unit: random stick ticks vs. a velocity predictor.
`timescale 1ns / 1ps
module tb_joystick_deadzone_smoother_unit;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRESSURE_CYCLES = 300;
  localparam int PHASE_TICKS = 98;
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  typedef struct {
    logic signed [15:0] fwd;
    logic signed [15:0] side;
    logic signed [15:0] turn;
    logic [3:0]         count;
  } stick_t;

  typedef struct {
    logic [15:0] fwd;
    logic [15:0] side;
    logic [15:0] turn;
    logic        stop;
  } vel_cmd_t;

  class velocity_scoreboard;
    logic [14:0] deadzone;
    logic [14:0] lin_limit;
    logic [14:0] ang_limit;
    logic [15:0] lin_scale;
    logic [15:0] ang_scale;
    logic [16:0] weight;
    int          avg_fwd;
    int          avg_side;
    int          avg_turn;
    bit          stop_sent;
    vel_cmd_t    pending[$];
    int          ticks;
    int          cmds;
    int          stops;
    int          mismatches;

    function new();
      deadzone = jds_pkg::DEADZONE_RST;
      lin_limit = jds_pkg::LIN_LIMIT_RST;
      ang_limit = jds_pkg::ANG_LIMIT_RST;
      lin_scale = jds_pkg::LIN_SCALE_RST;
      ang_scale = jds_pkg::ANG_SCALE_RST;
      weight = jds_pkg::WEIGHT_RST;
      avg_fwd = 0;
      avg_side = 0;
      avg_turn = 0;
      stop_sent = 1'b1;
      ticks = 0;
      cmds = 0;
      stops = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] data);
      case (idx)
        jds_pkg::REG_DEADZONE:  deadzone = data[14:0];
        jds_pkg::REG_LIN_LIMIT: lin_limit = data[14:0];
        jds_pkg::REG_ANG_LIMIT: ang_limit = data[14:0];
        jds_pkg::REG_LIN_SCALE: lin_scale = data[15:0];
        jds_pkg::REG_ANG_SCALE: ang_scale = data[15:0];
        jds_pkg::REG_WEIGHT:    weight = data;
        default: ;
      endcase
    endfunction

    function int shape(logic signed [15:0] a, logic [15:0] scale, logic [14:0] limit);
      longint mag;
      longint t;
      mag = (a < 0) ? -longint'(a) : longint'(a);
      if (mag < longint'(deadzone)) return 0;
      t = ((mag - longint'(deadzone)) * longint'(scale)) >>> 15;
      if (t > longint'(limit)) t = longint'(limit);
      return (a < 0) ? -int'(t) : int'(t);
    endfunction

    function int blend(int avg, int target, longint w);
      longint sum;
      longint mag;
      longint q;
      sum = w * longint'(target) * 65536 + (longint'(jds_pkg::WEIGHT_ONE) - w) * longint'(avg);
      mag = (sum < 0) ? -sum : sum;
      q = mag >>> 16;
      return int'((sum < 0) ? -q : q);
    endfunction

    function bit near_zero(int v);
      return v > -jds_pkg::ZERO_TOL && v < jds_pkg::ZERO_TOL;
    endfunction

    function logic [15:0] to_q12(int v);
      longint mag;
      longint r;
      mag = (v < 0) ? -longint'(v) : longint'(v);
      r = (mag + 32768) >>> 16;
      if (v < 0) r = -r;
      return r[15:0];
    endfunction

    function void note_tick(stick_t t);
      int       tf;
      int       ts;
      int       tt;
      longint   w;
      vel_cmd_t c;
      tf = 0;
      ts = 0;
      tt = 0;
      w = (weight > jds_pkg::WEIGHT_ONE) ? longint'(jds_pkg::WEIGHT_ONE) : longint'(weight);
      if (t.count >= 2) tf = shape(t.fwd, lin_scale, lin_limit);
      if (t.count >= 1) ts = shape(t.side, lin_scale, lin_limit);
      if (t.count >= 4) tt = shape(t.turn, ang_scale, ang_limit);
      avg_fwd = blend(avg_fwd, tf, w);
      avg_side = blend(avg_side, ts, w);
      avg_turn = blend(avg_turn, tt, w);
      ticks++;
      if (near_zero(avg_fwd) && near_zero(avg_side) && near_zero(avg_turn)) begin
        if (stop_sent) return;
        stop_sent = 1'b1;
        c = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
        stop_sent = 1'b0;
        c = '{to_q12(avg_fwd), to_q12(avg_side), to_q12(avg_turn), 1'b0};
      end
      pending.push_back(c);
    endfunction

    function void check_cmd(logic [47:0] d, logic stop);
      vel_cmd_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: fwd %0d side %0d turn %0d stop %0b",
                   $signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]), stop);
        return;
      end
      want = pending.pop_front();
      cmds++;
      if (want.stop) stops++;
      if (d[15:0] !== want.fwd || d[31:16] !== want.side || d[47:32] !== want.turn ||
          stop !== want.stop) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("command %0d: expected fwd %0d side %0d turn %0d stop %0b,",
                   cmds, $signed(want.fwd), $signed(want.side), $signed(want.turn),
                   want.stop);
          $display("  got fwd %0d side %0d turn %0d stop %0b",
                   $signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]), stop);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  velocity_scoreboard sb;
  bit tx_calm;
  bit rx_calm;
  int rx_hold;
  int n_writes;
  int n_settings;
  int idle_cycles;
  int ph;
  int sent;
  int run;

  joystick_deadzone_smoother_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stick_t stick(logic signed [15:0] f, logic signed [15:0] s,
                                   logic signed [15:0] t, logic [3:0] c);
    stick_t r;
    r.fwd = f;
    r.side = s;
    r.turn = t;
    r.count = c;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_axis(logic [14:0] dz);
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = {1'b0, dz};
      3: v = -{1'b0, dz};
      4: begin
        v = {1'b0, dz} + 16'($urandom_range(0, 3)) - 16'd2;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] rand_inside(logic [14:0] dz);
    logic [15:0] v;
    if (dz == 0) return 16'sd0;
    v = 16'($urandom_range(0, dz - 1));
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic stick_t rand_motion(logic [14:0] dz);
    logic [3:0] c;
    c = $urandom_range(0, 1) ? 4'($urandom) : 4'($urandom_range(4, 15));
    return stick(rand_axis(dz), rand_axis(dz), rand_axis(dz), c);
  endfunction

  function automatic stick_t rand_quiet(logic [14:0] dz);
    logic [3:0] c;
    c = 4'($urandom);
    if (dz == 0 || $urandom_range(0, 2) == 0) c = 4'd0;
    return stick(rand_inside(dz), rand_inside(dz), rand_inside(dz), c);
  endfunction

  function automatic int unsigned pick(int unsigned top, int unsigned typ);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top;
      2: return $urandom_range(0, top);
      default: return $urandom_range(0, typ);
    endcase
  endfunction

  task automatic send_tick(stick_t t);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {4'd0, t.count, t.turn, t.side, t.fwd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold until every command is out, then idle with no input while the pipe clears
  task automatic settle();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      gap = rx_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_cmd(out_tdata, out_tuser[0]);
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL joystick_deadzone_smoother_unit");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold = 0;
    n_writes = 0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default registers: no stop before motion, extremes, deadzone edges, axis counts
    send_tick(stick(16'sd0, 16'sd0, 16'sd0, 4'd0));
    send_tick(stick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'd4));
    send_tick(stick(16'sh8000, 16'sh8000, 16'sh8000, 4'd15));
    send_tick(stick(16'sh7FFF, 16'sh8000, 16'sh7FFF, 4'd1));
    send_tick(stick(16'sh8000, 16'sh7FFF, 16'sh8000, 4'd2));
    send_tick(stick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'd3));
    send_tick(stick(16'sd3277, -16'sd3277, 16'sd3277, 4'd4));
    send_tick(stick(16'sd3276, -16'sd3276, -16'sd3276, 4'd4));
    send_tick(stick(16'sd3278, -16'sd3278, 16'sd3278, 4'd4));
    send_tick(stick(16'sh5555, 16'shAAAA, 16'sh1234, 4'hF));
    settle();

    // weight above one clamps to one: each stop is sent once, then silence until motion
    write_reg(jds_pkg::REG_WEIGHT, 17'h1FFFF);
    write_reg(REG_SPARE6, 17'h00123);
    n_settings++;
    send_tick(stick(16'sd20000, -16'sd20000, 16'sd30000, 4'd4));
    send_tick(stick(16'sd0, 16'sd0, 16'sd0, 4'd0));
    send_tick(stick(16'sd0, 16'sd0, 16'sd0, 4'd0));
    send_tick(stick(-16'sd1, 16'sd1, -16'sd1, 4'd15));
    send_tick(stick(16'sh8000, 16'sh8000, 16'sh8000, 4'd8));
    send_tick(stick(16'sd3277, 16'sd3277, 16'sd3277, 4'd15));
    settle();

    write_reg(jds_pkg::REG_DEADZONE, 17'd0);
    write_reg(jds_pkg::REG_LIN_LIMIT, 17'h07FFF);
    write_reg(jds_pkg::REG_ANG_LIMIT, 17'h07FFF);
    write_reg(jds_pkg::REG_LIN_SCALE, 17'h0FFFF);
    write_reg(jds_pkg::REG_ANG_SCALE, 17'h0FFFF);
    write_reg(jds_pkg::REG_WEIGHT, 17'd65536);
    n_settings++;
    send_tick(stick(16'sd1, -16'sd1, 16'sd1, 4'd4));
    send_tick(stick(16'sh8000, 16'sh8000, 16'sh8000, 4'd4));
    send_tick(stick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'd4));
    send_tick(stick(16'sd0, 16'sd0, 16'sd0, 4'd4));
    settle();

    // zero weight: averages never move
    write_reg(jds_pkg::REG_WEIGHT, 17'd0);
    write_reg(REG_SPARE7, 17'h1FFFF);
    n_settings++;
    send_tick(stick(16'sh7FFF, 16'sh8000, 16'sh7FFF, 4'd4));

    for (ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(jds_pkg::REG_DEADZONE, {2'($urandom), 15'(pick(32767, 8000))});
      write_reg(jds_pkg::REG_LIN_LIMIT, {2'($urandom), 15'(pick(32767, 32767))});
      write_reg(jds_pkg::REG_ANG_LIMIT, {2'($urandom), 15'(pick(32767, 32767))});
      write_reg(jds_pkg::REG_LIN_SCALE, {1'($urandom), 16'(pick(65535, 65535))});
      write_reg(jds_pkg::REG_ANG_SCALE, {1'($urandom), 16'(pick(65535, 65535))});
      write_reg(jds_pkg::REG_WEIGHT, ($urandom_range(0, 3) == 0) ?
                17'(pick(131071, 65536)) : 17'($urandom_range(20000, 65536)));
      write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, 17'($urandom));
      n_settings++;
      tx_calm = ph[0];
      rx_calm = ph[1];
      if (ph == 2) rx_hold = PRESSURE_CYCLES;
      sent = 0;
      while (sent < PHASE_TICKS) begin
        run = $urandom_range(2, 14);
        repeat (run) begin
          send_tick(rand_motion(sb.deadzone));
          sent++;
        end
        run = $urandom_range(1, 12);
        repeat (run) begin
          if ($urandom_range(0, 7) == 0)
            send_tick(rand_motion(sb.deadzone));
          else
            send_tick(rand_quiet(sb.deadzone));
          sent++;
        end
      end
    end

    settle();
    $display("Sent %0d stick ticks across %0d register settings (%0d register writes),",
             sb.ticks, n_settings, n_writes);
    $display("checked %0d velocity commands including %0d stops.", sb.cmds, sb.stops);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS joystick_deadzone_smoother_unit");
    else
      $display("FAIL joystick_deadzone_smoother_unit");
    $finish;
  end

endmodule

>>> files.f
src/jds_pkg.sv
src/jds_cfg_regs.sv
src/jds_datapath.sv
src/jds_ctrl.sv
src/joystick_deadzone_smoother_unit.sv
test/tb_joystick_deadzone_smoother_unit.sv
